// ===== rtl/bounded_work_queue_with_expiry_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bounded work queue unit
// Concurrent checks sampled on clk and held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_WORK_QUEUE_WITH_EXPIRY_UNIT_MACROS_SVH
`define BOUNDED_WORK_QUEUE_WITH_EXPIRY_UNIT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define BWQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// An expression that must never be true.
`define BWQ_ASSERT_NEVER(label, expr, msg) \
	`BWQ_ASSERT(label, !(expr), msg)

`endif

// ===== rtl/bwq_pkg.sv =====
// ----------------------------------------------------------------------------
// bwq_pkg
// Shared widths, codes and types of the bounded work queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bwq_pkg;

	localparam int DEFAULT_QUEUE_DEPTH = 16;

	localparam int CAP_W      = 5;
	localparam int TIMEOUT_W  = 32;
	localparam int HANDLE_W   = 32;
	localparam int LENGTH_W   = 16;
	localparam int CONTEXT_W  = 32;
	localparam int STAMP_W    = 32;
	localparam int STAT_W     = 32;
	localparam int CMD_W      = 3;
	localparam int STATUS_W   = 2;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH     = 3'd0,
		CMD_POP      = 3'd1,
		CMD_TICK     = 3'd2,
		CMD_SHUTDOWN = 3'd3,
		CMD_CANCEL   = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_SHUT  = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAPACITY = 1'd0,
		REG_TIMEOUT  = 1'd1
	} cfg_reg_t;

	// One queue slot as it sits in the descriptor memory.
	typedef struct packed {
		logic [HANDLE_W-1:0]  handle;
		logic [LENGTH_W-1:0]  length;
		logic [CONTEXT_W-1:0] context_word;
		logic [STAMP_W-1:0]   stamp;
	} slot_t;

	localparam int SLOT_W = HANDLE_W + LENGTH_W + CONTEXT_W + STAMP_W;

endpackage

`default_nettype wire

// ===== rtl/bwq_ram.sv =====
// ----------------------------------------------------------------------------
// bwq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module bwq_ram
	import bwq_pkg::*;
#(
	parameter int WIDTH = SLOT_W,
	parameter int DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bounded_work_queue_with_expiry_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_work_queue_with_expiry_unit
// Circular queue of work descriptors with enqueue time stamps, expiry on pop,
// shutdown latch and five wrapping statistics counters.
//
//   channel   direction  handshake           payload
//   command   in         in_valid/in_stall   cmd, item_handle/length/context
//   result    out        out_valid/out_stall status, descriptor, age, stats
//   config    in         cfg_we              cfg_index, cfg_wdata
//
// A command transfer loads stage 1, and stage 1 moves its result into the
// output register once that register is empty or not stalled; one command
// per cycle is sustained while out_stall is low. The descriptor memory
// read, with registered data, sets the extra stage, and the expiry count is
// settled in that stage. Reset clears pointers, counters and the shutdown
// latch at once; the memory is not cleared. A stalled result holds the stage
// behind it, and the command side stalls only when that stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_work_queue_with_expiry_unit_macros.svh"

module bounded_work_queue_with_expiry_unit
	import bwq_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,

	input  wire logic                                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0]                 cfg_index,
	input  wire logic [CFG_DATA_W-1:0]                cfg_wdata,

	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [CMD_W-1:0]                     cmd,
	input  wire logic [HANDLE_W-1:0]                  item_handle,
	input  wire logic [LENGTH_W-1:0]                  item_length,
	input  wire logic [CONTEXT_W-1:0]                 item_context,

	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic [STATUS_W-1:0]                       status,
	output logic [HANDLE_W-1:0]                       out_handle,
	output logic [LENGTH_W-1:0]                       out_length,
	output logic [CONTEXT_W-1:0]                      out_context,
	output logic [STAMP_W-1:0]                        item_age,
	output logic                                      expired,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]          depth,
	output logic [STAT_W-1:0]                         pushed_total,
	output logic [STAT_W-1:0]                         popped_total,
	output logic [STAT_W-1:0]                         dropped_total,
	output logic [STAT_W-1:0]                         expired_total,
	output logic [STAT_W-1:0]                         cancelled_total
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Command stage contents waiting for the memory read.
	typedef struct packed {
		status_t             status;
		logic                pop_ok;
		logic [STAMP_W-1:0]  tick;
		logic [CNT_W-1:0]    depth;
		logic [STAT_W-1:0]   pushed;
		logic [STAT_W-1:0]   popped;
		logic [STAT_W-1:0]   dropped;
		logic [STAT_W-1:0]   cancelled;
	} stage_t;

	typedef struct packed {
		status_t              status;
		logic [HANDLE_W-1:0]  handle;
		logic [LENGTH_W-1:0]  length;
		logic [CONTEXT_W-1:0] context_word;
		logic [STAMP_W-1:0]   age;
		logic                 expired;
		logic [CNT_W-1:0]     depth;
		logic [STAT_W-1:0]    pushed;
		logic [STAT_W-1:0]    popped;
		logic [STAT_W-1:0]    dropped;
		logic [STAT_W-1:0]    expired_cnt;
		logic [STAT_W-1:0]    cancelled;
	} result_t;

	// Configuration and architectural state.
	logic [CAP_W-1:0]     capacity_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic [PTR_W-1:0]     wptr_q;
	logic [PTR_W-1:0]     rptr_q;
	logic [CNT_W-1:0]     fill_q;
	logic [STAMP_W-1:0]   tick_q;
	logic                 stopped_q;
	logic [STAT_W-1:0]    pushed_q;
	logic [STAT_W-1:0]    popped_q;
	logic [STAT_W-1:0]    dropped_q;
	logic [STAT_W-1:0]    expired_q;
	logic [STAT_W-1:0]    cancelled_q;

	logic                 valid_s1;
	stage_t               stage_s1;
	logic                 out_valid_q;
	result_t              res_q;

	logic [CMP_W-1:0]     cap_ext;
	logic [CNT_W-1:0]     eff_cap;
	logic [CNT_W-1:0]     wptr_inc;
	logic [CNT_W-1:0]     rptr_inc;
	logic [PTR_W-1:0]     wptr_next;
	logic [PTR_W-1:0]     rptr_next;

	logic                 in_fire;
	logic                 s1_adv;
	logic                 push_ok;
	logic                 push_drop;
	logic                 pop_ok;
	logic                 do_tick;
	logic                 do_shut;
	logic                 do_cancel;
	status_t              cmd_status;
	logic [CNT_W-1:0]     fill_next;
	logic [STAT_W-1:0]    pushed_next;
	logic [STAT_W-1:0]    popped_next;
	logic [STAT_W-1:0]    dropped_next;
	logic [STAT_W-1:0]    cancelled_next;

	logic                 ram_we;
	logic                 ram_re;
	slot_t                wslot;
	logic [SLOT_W-1:0]    ram_rdata;
	slot_t                rslot;
	logic [STAMP_W-1:0]   age_s1;
	logic                 hit_s1;

	// ------------------------------------------------------------------
	// Effective capacity and pointer wrap
	// ------------------------------------------------------------------
	always_comb begin
		cap_ext = CMP_W'(capacity_q);
		if (cap_ext == '0) begin
			cap_ext = CMP_W'(1);
		end else if (cap_ext > CMP_W'(QUEUE_DEPTH)) begin
			cap_ext = CMP_W'(QUEUE_DEPTH);
		end
		eff_cap = cap_ext[CNT_W-1:0];
	end

	// A pointer left beyond a reduced capacity wraps to slot 0 on its next step.
	assign wptr_inc  = CNT_W'(wptr_q) + CNT_W'(1);
	assign rptr_inc  = CNT_W'(rptr_q) + CNT_W'(1);
	assign wptr_next = (wptr_inc >= eff_cap) ? '0 : wptr_inc[PTR_W-1:0];
	assign rptr_next = (rptr_inc >= eff_cap) ? '0 : rptr_inc[PTR_W-1:0];

	// ------------------------------------------------------------------
	// Handshake
	// ------------------------------------------------------------------
	assign s1_adv   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_fire  = in_valid && !in_stall;

	// ------------------------------------------------------------------
	// Command decode
	// ------------------------------------------------------------------
	always_comb begin
		push_ok    = 1'b0;
		push_drop  = 1'b0;
		pop_ok     = 1'b0;
		do_tick    = 1'b0;
		do_shut    = 1'b0;
		do_cancel  = 1'b0;
		cmd_status = ST_OK;
		unique case (cmd_t'(cmd))
			CMD_PUSH: begin
				if (stopped_q) begin
					push_drop  = 1'b1;
					cmd_status = ST_SHUT;
				end else if (fill_q >= eff_cap) begin
					push_drop  = 1'b1;
					cmd_status = ST_FULL;
				end else begin
					push_ok = 1'b1;
				end
			end
			CMD_POP: begin
				if (fill_q == '0) begin
					cmd_status = ST_EMPTY;
				end else begin
					pop_ok = 1'b1;
				end
			end
			CMD_TICK:     do_tick   = 1'b1;
			CMD_SHUTDOWN: do_shut   = 1'b1;
			CMD_CANCEL:   do_cancel = 1'b1;
			default: begin
				// Unused command codes change nothing and report ok.
			end
		endcase
	end

	assign fill_next      = fill_q + CNT_W'(push_ok) - CNT_W'(pop_ok);
	assign pushed_next    = pushed_q + STAT_W'(push_ok);
	assign popped_next    = popped_q + STAT_W'(pop_ok);
	assign dropped_next   = dropped_q + STAT_W'(push_drop);
	assign cancelled_next = cancelled_q + STAT_W'(do_cancel);

	// ------------------------------------------------------------------
	// Descriptor memory
	// ------------------------------------------------------------------
	assign ram_we = in_fire && push_ok;
	assign ram_re = in_fire && pop_ok;

	always_comb begin
		wslot.handle       = item_handle;
		wslot.length       = item_length;
		wslot.context_word = item_context;
		wslot.stamp        = tick_q;
	end

	bwq_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (QUEUE_DEPTH)
	) u_slot_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wptr_q),
		.wdata (wslot),
		.re    (ram_re),
		.raddr (rptr_q),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			timeout_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CAPACITY: capacity_q <= cfg_wdata[CAP_W-1:0];
				REG_TIMEOUT:  timeout_q  <= cfg_wdata[TIMEOUT_W-1:0];
				default:      capacity_q <= capacity_q;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Queue state, updated when a command transfers in
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q      <= '0;
			rptr_q      <= '0;
			fill_q      <= '0;
			tick_q      <= '0;
			stopped_q   <= 1'b0;
			pushed_q    <= '0;
			popped_q    <= '0;
			dropped_q   <= '0;
			cancelled_q <= '0;
		end else if (in_fire) begin
			if (push_ok) begin
				wptr_q <= wptr_next;
			end
			if (pop_ok) begin
				rptr_q <= rptr_next;
			end
			if (do_tick) begin
				tick_q <= tick_q + STAMP_W'(1);
			end
			if (do_shut) begin
				stopped_q <= 1'b1;
			end
			fill_q      <= fill_next;
			pushed_q    <= pushed_next;
			popped_q    <= popped_next;
			dropped_q   <= dropped_next;
			cancelled_q <= cancelled_next;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: memory data arrives, age and expiry are settled
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			stage_s1.status    <= cmd_status;
			stage_s1.pop_ok    <= pop_ok;
			stage_s1.tick      <= tick_q;
			stage_s1.depth     <= fill_next;
			stage_s1.pushed    <= pushed_next;
			stage_s1.popped    <= popped_next;
			stage_s1.dropped   <= dropped_next;
			stage_s1.cancelled <= cancelled_next;
		end
	end

	// The read data stays put while stage 1 waits: no new read is issued
	// until the stage moves on.
	assign rslot  = slot_t'(ram_rdata);
	assign age_s1 = stage_s1.tick - rslot.stamp;
	assign hit_s1 = stage_s1.pop_ok && (timeout_q != '0) && (age_s1 > timeout_q);

	// The expiry counter is kept here, so each result sees every earlier pop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expired_q <= '0;
		end else if (s1_adv) begin
			expired_q <= expired_q + STAT_W'(hit_s1);
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q.status       <= stage_s1.status;
			res_q.handle       <= stage_s1.pop_ok ? rslot.handle : '0;
			res_q.length       <= stage_s1.pop_ok ? rslot.length : '0;
			res_q.context_word <= stage_s1.pop_ok ? rslot.context_word : '0;
			res_q.age          <= stage_s1.pop_ok ? age_s1 : '0;
			res_q.expired      <= hit_s1;
			res_q.depth        <= stage_s1.depth;
			res_q.pushed       <= stage_s1.pushed;
			res_q.popped       <= stage_s1.popped;
			res_q.dropped      <= stage_s1.dropped;
			res_q.expired_cnt  <= expired_q + STAT_W'(hit_s1);
			res_q.cancelled    <= stage_s1.cancelled;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = res_q.status;
	assign out_handle      = res_q.handle;
	assign out_length      = res_q.length;
	assign out_context     = res_q.context_word;
	assign item_age        = res_q.age;
	assign expired         = res_q.expired;
	assign depth           = res_q.depth;
	assign pushed_total    = res_q.pushed;
	assign popped_total    = res_q.popped;
	assign dropped_total   = res_q.dropped;
	assign expired_total   = res_q.expired_cnt;
	assign cancelled_total = res_q.cancelled;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`BWQ_ASSERT(a_fill_bound, fill_q <= CNT_W'(QUEUE_DEPTH), "fill count above built depth")
	`BWQ_ASSERT(a_read_nonempty, ram_re |-> fill_q != '0, "slot read from an empty queue")
	`BWQ_ASSERT_NEVER(a_ram_one_access, ram_we && ram_re, "push and pop in the same cycle")
	`BWQ_ASSERT(a_s1_hold, valid_s1 && !s1_adv |=> valid_s1 && $stable(stage_s1),
		"stage 1 lost or changed while blocked")
	`BWQ_ASSERT(a_expired_pop, out_valid_q && res_q.expired |-> res_q.status == ST_OK
		&& res_q.age != '0, "expired flag on a result that is no pop")

endmodule

`default_nettype wire
